### hw/rtl/jcs_pkg.sv
package jcs_pkg;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_LINE  = 2'd1;
   localparam logic [1:0] MODE_BLOCK = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] mode;
      logic       in_str;
      logic       skip;
      logic [7:0] held;
      logic       held_valid;
      logic [7:0] back_one;
      logic [7:0] back_two;
      logic [1:0] bbh;        // bytes before held byte, saturates at 2
   } strm_type;

   typedef struct packed {
      logic       comment;
      logic [1:0] mode;
      logic       in_str;
      logic       skip;
   } judge_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       out_last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic is_ws(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF ||
             c == CH_VT || c == CH_FF || c == CH_CR;
   endfunction

   // Classify byte cur (held position) given lookahead nxt and stream state st.
   function automatic judge_type judge_byte(input strm_type st, input logic [7:0] cur,
                                            input logic [7:0] nxt);
      judge_type j;
      logic      esc;
      j.comment = 1'b0;
      j.mode    = st.mode;
      j.in_str  = st.in_str;
      j.skip    = 1'b0;
      esc = (st.bbh == 2'd2) && (st.back_one == CH_BSLASH) && (st.back_two != CH_BSLASH);
      if (st.skip) begin
         j.comment = 1'b1;
      end else if (st.mode == MODE_NONE) begin
         if (cur == CH_QUOTE && !esc) begin
            j.in_str = ~st.in_str;
         end
         if (!j.in_str && cur == CH_SLASH && nxt == CH_SLASH) begin
            j.mode    = MODE_LINE;
            j.skip    = 1'b1;
            j.comment = 1'b1;
         end else if (!j.in_str && cur == CH_SLASH && nxt == CH_STAR) begin
            j.mode    = MODE_BLOCK;
            j.skip    = 1'b1;
            j.comment = 1'b1;
         end
      end else if (st.mode == MODE_LINE) begin
         if (cur == CH_LF) begin
            j.mode = MODE_NONE;
         end else begin
            j.comment = 1'b1;
         end
      end else begin
         // block comment (mode 3 behaves the same)
         j.comment = 1'b1;
         if (cur == CH_STAR && nxt == CH_SLASH) begin
            j.mode = MODE_NONE;
            j.skip = 1'b1;
         end
      end
      return j;
   endfunction

   function automatic result_type make_result(input logic [7:0] cur, input logic comment);
      result_type r;
      r.out_byte   = (comment && !is_ws(cur)) ? CH_SPACE : cur;
      r.byte_valid = 1'b1;
      r.out_last   = 1'b0;
      return r;
   endfunction

endpackage

### hw/rtl/json_comment_stripper.sv
// JSON comment stripper.
// req_* : input bytes of a JSON text, stream handshake; req_tlast marks the
//         last byte of a text. rsp_* : result bytes; rsp_tuser = 0 marks an
//         empty end-of-text marker (only when the last transaction yields no byte).
// csr_wr_en/csr_wr_data : keep_whitespace; 1 turns comment bytes into spaces
//         (whitespace passes), 0 drops them. Write only while idle.
// One byte is held back for lookahead, so a byte's result enters the output
// queue on the cycle the following byte is accepted and reaches rsp_* from the
// queue register. On the last byte both held and last byte are resolved at once.
// Throughput: one byte per cycle while req_tready is high; each transaction
// pushes at most two results into a 4-entry output queue, and req_tready is high
// while at least two entries are free. A last byte that yields two results
// pushes both at once. When rsp_tready is low the queue fills and req_tready drops.
// Reset empties the queue, clears the stream state and sets keep_whitespace.
module json_comment_stripper
   import jcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] byte_valid
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   logic                keep_ws_ff;
   logic                accept, pop;
   push_type            push;
   result_type          queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   result_type          head;

   assign req_tready = count_ff <= (QPTR_W+1)'(QUEUE_DEPTH - 2);
   assign accept     = req_tvalid && req_tready;
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = head.byte_valid;
   assign rsp_tlast  = head.out_last;
   assign pop        = rsp_tvalid && rsp_tready;

   jcs_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .keep_ws (keep_ws_ff),
      .push    (push)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + (QPTR_W+1)'(push.count) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ws_ff <= 1'b1;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            keep_ws_ff <= csr_wr_data;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/jcs_core.sv
module jcs_core
   import jcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   input  logic       keep_ws,
   output push_type   push
);

   strm_type   st_ff, st_in, nx;
   judge_type  j1, j2;
   logic       e1, e2;
   result_type r1, r2, marker;

   always_comb begin
      nx = st_ff;
      j1 = judge_byte(st_ff, st_ff.held, in_byte);
      e1 = st_ff.held_valid && (!j1.comment || keep_ws);
      r1 = make_result(st_ff.held, j1.comment);
      if (st_ff.held_valid) begin
         nx.mode     = j1.mode;
         nx.in_str   = j1.in_str;
         nx.skip     = j1.skip;
         nx.back_two = st_ff.back_one;
         nx.back_one = st_ff.held;
         nx.bbh      = (st_ff.bbh == 2'd2) ? 2'd2 : st_ff.bbh + 2'd1;
      end else begin
         nx.bbh = 2'd0;
      end
      nx.held       = in_byte;
      nx.held_valid = 1'b1;

      // at the end of text the new byte is judged right away, no lookahead
      j2 = judge_byte(nx, in_byte, 8'd0);
      e2 = in_last && (!j2.comment || keep_ws);
      r2 = make_result(in_byte, j2.comment);

      marker.out_byte   = 8'd0;
      marker.byte_valid = 1'b0;
      marker.out_last   = 1'b1;

      push.first  = r1;
      push.second = r2;
      push.count  = 2'd0;
      if (e1 && e2) begin
         push.second.out_last = 1'b1;
         push.count           = 2'd2;
      end else if (e1) begin
         push.first.out_last = in_last;
         push.count          = 2'd1;
      end else if (e2) begin
         push.first          = r2;
         push.first.out_last = 1'b1;
         push.count          = 2'd1;
      end else if (in_last) begin
         push.first = marker;
         push.count = 2'd1;
      end
      if (!accept) begin
         push.count = 2'd0;
      end

      st_in = st_ff;
      if (accept) begin
         st_in = in_last ? '0 : nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

endmodule

### tb/json_comment_stripper_tb.sv
`timescale 1ns / 1ps

module json_comment_stripper_tb;
   import jcs_pkg::*;

   localparam int LIMIT_CYCLES = 250000;
   localparam int HOLD_CYCLES  = 300;

   // Expected stripped output, tracked byte by byte from the accepted input.
   class stripped_text_board;
      bit         keep_ws;
      logic [1:0] mode;
      bit         in_str;
      bit         skip_next;
      bit         held_ok;
      logic [7:0] held;
      logic [7:0] prev1;
      logic [7:0] prev2;
      int         seen;
      result_type stripped_due[$];
      int         errors;

      function new();
         keep_ws = 1'b1;
         errors  = 0;
         restart();
      endfunction

      function void restart();
         mode      = MODE_NONE;
         in_str    = 1'b0;
         skip_next = 1'b0;
         held_ok   = 1'b0;
         held      = 8'h00;
         prev1     = 8'h00;
         prev2     = 8'h00;
         seen      = 0;
      endfunction

      function bit blank(logic [7:0] c);
         return c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
      endfunction

      // Decide whether the held byte belongs to a comment, given the byte after it.
      function bit held_is_comment(logic [7:0] nxt);
         if (skip_next) begin
            skip_next = 1'b0;
            return 1'b1;
         end
         case (mode)
            MODE_NONE: begin
               if (held == CH_QUOTE &&
                   !(seen >= 2 && prev1 == CH_BSLASH && prev2 != CH_BSLASH))
                  in_str = ~in_str;
               if (in_str)
                  return 1'b0;
               if (held == CH_SLASH && (nxt == CH_SLASH || nxt == CH_STAR)) begin
                  mode      = (nxt == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
                  skip_next = 1'b1;
                  return 1'b1;
               end
               return 1'b0;
            end
            MODE_LINE: begin
               if (held == CH_LF) begin
                  mode = MODE_NONE;
                  return 1'b0;
               end
               return 1'b1;
            end
            default: begin
               if (held == CH_STAR && nxt == CH_SLASH) begin
                  mode      = MODE_NONE;
                  skip_next = 1'b1;
               end
               return 1'b1;
            end
         endcase
      endfunction

      function void resolve_held(logic [7:0] nxt);
         result_type r;
         r.out_byte   = held;
         r.byte_valid = 1'b1;
         r.out_last   = 1'b0;
         if (held_is_comment(nxt)) begin
            if (!keep_ws)
               return;
            if (!blank(held))
               r.out_byte = CH_SPACE;
         end
         stripped_due.insert(stripped_due.size(), r);
      endfunction

      function void take_raw_byte(logic [7:0] b, bit last);
         int         queued;
         result_type r;
         queued = stripped_due.size();
         if (held_ok) begin
            resolve_held(b);
            prev2 = prev1;
            prev1 = held;
            if (seen < 2)
               seen++;
         end else begin
            seen = 0;
         end
         held    = b;
         held_ok = 1'b1;
         if (last) begin
            resolve_held(8'h00);
            if (stripped_due.size() == queued) begin
               r = '0;   // empty end-of-text marker
            end else begin
               r = stripped_due.pop_back();
            end
            r.out_last = 1'b1;
            stripped_due.insert(stripped_due.size(), r);
            restart();
         end
      endfunction

      function void check_out_byte(logic [7:0] data, logic user, logic last);
         result_type e;
         if (stripped_due.size() == 0) begin
            $error("unexpected transaction: out_byte %02h byte_valid %0b out_last %0b",
                   data, user, last);
            errors++;
            return;
         end
         e = stripped_due.pop_front();
         if (data !== e.out_byte) begin
            $error("out_byte: expected %02h, actual %02h", e.out_byte, data);
            errors++;
         end
         if (user !== e.byte_valid) begin
            $error("byte_valid: expected %0b, actual %0b", e.byte_valid, user);
            errors++;
         end
         if (last !== e.out_last) begin
            $error("out_last: expected %0b, actual %0b", e.out_last, last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_byte
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tuser;           // [0] byte_valid
   logic       rsp_tlast;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   stripped_text_board sb = new();

   bit         tx_idle_on = 1'b1;
   bit         rx_idle_on = 1'b1;
   int         holds_asked = 0;
   int         holds_done = 0;
   int         hold_left = 0;
   int         cycles = 0;
   logic [7:0] raw_text[$];

   json_comment_stripper dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("json_comment_stripper_tb: FAIL");
         $finish;
      end
   end

   // Output side: check each transaction, then pick the next tready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_out_byte(rsp_tdata, rsp_tuser, rsp_tlast);
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= rx_idle_on ? ($urandom_range(99) >= 31) : 1'b1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input bit last);
      while (tx_idle_on && $urandom_range(99) < 31) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      sb.take_raw_byte(b, last);
   endtask

   task automatic send_string(input string s, input bit last_at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], last_at_end && i == s.len() - 1);
   endtask

   task automatic set_keep_ws(input bit v);
      while (sb.stripped_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.keep_ws = v;
   endtask

   function automatic logic [7:0] pick_filler();
      case ($urandom_range(0, 11))
         0: return CH_SLASH;
         1: return CH_STAR;
         2: return CH_QUOTE;
         3: return CH_BSLASH;
         4: return CH_LF;
         5: return CH_CR;
         6: return CH_SPACE;
         7: return $urandom_range(1) ? CH_TAB : ($urandom_range(1) ? CH_VT : CH_FF);
         8: return 8'($urandom_range(255));
         default: return 8'($urandom_range(8'h61, 8'h7A));
      endcase
   endfunction

   function automatic void add_raw(logic [7:0] c);
      raw_text.insert(raw_text.size(), c);
   endfunction

   function automatic void add_filler(int n);
      for (int i = 0; i < n; i++)
         add_raw(pick_filler());
   endfunction

   // Mostly well-formed comments and strings with random content, plus noise.
   function automatic void build_text();
      int target;
      target = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      raw_text.delete();
      while (raw_text.size() < target) begin
         case ($urandom_range(0, 7))
            0: begin
               add_raw(CH_SLASH);
               add_raw(CH_SLASH);
               add_filler($urandom_range(0, 6));
               if ($urandom_range(3) == 0)
                  add_raw(CH_CR);
               if ($urandom_range(7) != 0)
                  add_raw(CH_LF);
            end
            1: begin
               add_raw(CH_SLASH);
               add_raw(CH_STAR);
               add_filler($urandom_range(0, 6));
               if ($urandom_range(7) != 0) begin
                  add_raw(CH_STAR);
                  add_raw(CH_SLASH);
               end
            end
            2: begin
               add_raw(CH_QUOTE);
               add_filler($urandom_range(0, 5));
               if ($urandom_range(1)) begin
                  add_raw(CH_BSLASH);
                  add_raw(CH_QUOTE);
               end
               add_filler($urandom_range(0, 3));
               add_raw(CH_QUOTE);
            end
            3: add_filler($urandom_range(1, 6));
            4: begin
               repeat ($urandom_range(1, 4))
                  add_raw(8'($urandom_range(255)));
            end
            5: begin
               // escaped and double-backslash quotes
               add_raw(CH_BSLASH);
               if ($urandom_range(1))
                  add_raw(CH_BSLASH);
               add_raw(CH_QUOTE);
            end
            6: begin
               repeat ($urandom_range(1, 3))
                  add_raw($urandom_range(1) ? CH_SPACE : CH_LF);
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  add_raw($urandom_range(1) ? CH_SLASH : CH_STAR);
            end
         endcase
      end
   endfunction

   task automatic run_phase(input int quota, input bit hold);
      int sent;
      bit asked;
      sent  = 0;
      asked = 1'b0;
      while (sent < quota) begin
         build_text();
         foreach (raw_text[i]) begin
            send_byte(raw_text[i], i == raw_text.size() - 1);
            sent++;
            // long receiver stall while input keeps coming
            if (hold && !asked && sent >= 60) begin
               holds_asked++;
               asked = 1'b1;
            end
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed texts, reset setting (comment bytes become spaces)
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_string("//a", 1'b0);
      send_byte(CH_CR, 1'b0);
      send_byte(CH_LF, 1'b1);
      send_string("/*/*/", 1'b1);
      send_string("\"\\\"//\"", 1'b1);
      send_string("/*x", 1'b1);
      send_string("//", 1'b1);
      req_tvalid <= 1'b0;

      set_keep_ws(1'b0);
      run_phase(380, 1'b0);

      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      set_keep_ws(1'b1);
      run_phase(380, 1'b1);

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      set_keep_ws(1'b0);
      run_phase(350, 1'b1);

      set_keep_ws(1'b1);
      run_phase(320, 1'b0);

      waited = 0;
      while (sb.stripped_due.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (16) @(posedge clock);
      if (sb.stripped_due.size() != 0) begin
         $error("%0d expected transactions never arrived", sb.stripped_due.size());
         sb.errors++;
      end
      if (sb.errors == 0)
         $display("json_comment_stripper_tb: PASS");
      else
         $display("json_comment_stripper_tb: FAIL");
      $finish;
   end

endmodule
